[rtl/spq_pkg.sv]
// shared constants, types and helpers for the sorted priority queue
`timescale 1ns / 1ps
package spq_pkg;

   // queue geometry
   localparam int DEPTH    = 64;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);

   // payload widths
   localparam int VALUE_W  = 32;
   localparam int PRIO_W   = 16;
   localparam int ENTRY_W  = VALUE_W + PRIO_W;
   localparam int STATUS_W = 2;
   localparam int FILL_W   = 7;

   // operation codes
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic                capture;
      logic                read_head;
      logic                pop;
      logic                read_next;
      logic                shift_up;
      logic                place_above;
      logic                place_head;
      logic                count_inc;
      logic                set_status;
      logic [STATUS_W-1:0] status_code;
      logic                respond;
   } spq_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic empty;
      logic full;
      logic prio_ge;
      logic scan_last;
      logic rsp_busy;
   } spq_stat_type;

   // circular address step forward
   function automatic logic [ADDR_W-1:0] addr_inc(input logic [ADDR_W-1:0] a);
      logic [ADDR_W-1:0] r;
      if (a == ADDR_W'(DEPTH - 1)) r = '0;
      else r = a + ADDR_W'(1);
      return r;
   endfunction

   // circular address step back
   function automatic logic [ADDR_W-1:0] addr_dec(input logic [ADDR_W-1:0] a);
      logic [ADDR_W-1:0] r;
      if (a == '0) r = ADDR_W'(DEPTH - 1);
      else r = a - ADDR_W'(1);
      return r;
   endfunction

endpackage

[rtl/spq_req_if.sv]
// request channel: command, value and priority with valid/ready
`timescale 1ns / 1ps
interface spq_req_if;
   import spq_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      command;
   logic signed [VALUE_W-1:0] item_value;
   logic signed [PRIO_W-1:0]  item_priority;

   modport source (output valid, output command, output item_value,
                   output item_priority, input ready);
   modport sink   (input valid, input command, input item_value,
                   input item_priority, output ready);
endinterface

[rtl/spq_rsp_if.sv]
// response channel: status, removed value and fill count with valid/ready
`timescale 1ns / 1ps
interface spq_rsp_if;
   import spq_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [STATUS_W-1:0]       status;
   logic signed [VALUE_W-1:0] removed_value;
   logic [FILL_W-1:0]         fill_count;

   modport source (output valid, output status, output removed_value,
                   output fill_count, input ready);
   modport sink   (input valid, input status, input removed_value,
                   input fill_count, output ready);
endinterface

[rtl/spq_ram.sv]
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module spq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/spq_ctrl.sv]
// controller state machine sequencing insert scans and removes
`timescale 1ns / 1ps
module spq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_command,
   output logic                  req_ready,
   input  spq_pkg::spq_stat_type stat,
   output spq_pkg::spq_cmd_type  cmd
);
   import spq_pkg::*;

   typedef enum logic [2:0] {
      IDLE,
      REM_WAIT,
      FIRST,
      SCAN,
      PLACE,
      RESPOND
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, req_ready_in;
   logic      accept;

   assign accept    = req_valid && req_ready_ff;
   assign req_ready = req_ready_ff;

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               if (req_command == CMD_REMOVE) begin
                  if (stat.empty) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STATUS_UNDERFLOW;
                     state_in        = RESPOND;
                  end else begin
                     cmd.read_head = 1'b1;
                     state_in      = REM_WAIT;
                  end
               end else begin
                  if (stat.full) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STATUS_OVERFLOW;
                     state_in        = RESPOND;
                  end else if (stat.empty) begin
                     state_in = PLACE;
                  end else begin
                     state_in = FIRST;
                  end
               end
            end
         end
         REM_WAIT: begin
            cmd.pop  = 1'b1;
            state_in = RESPOND;
         end
         FIRST: begin
            cmd.read_next = 1'b1;
            state_in      = SCAN;
         end
         SCAN: begin
            if (stat.prio_ge) begin
               cmd.place_above = 1'b1;
               cmd.count_inc   = 1'b1;
               state_in        = RESPOND;
            end else begin
               cmd.shift_up = 1'b1;
               if (stat.scan_last) begin
                  state_in = PLACE;
               end else begin
                  cmd.read_next = 1'b1;
               end
            end
         end
         PLACE: begin
            cmd.place_head = 1'b1;
            cmd.count_inc  = 1'b1;
            state_in       = RESPOND;
         end
         RESPOND: begin
            if (!stat.rsp_busy) begin
               cmd.respond = 1'b1;
               state_in    = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
      req_ready_in = (state_in == IDLE);
   end

   // state and registered ready
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         req_ready_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= req_ready_in;
      end
   end
endmodule

[rtl/spq_dp.sv]
// datapath: entry memory as a circular sorted array, pointers and response registers
`timescale 1ns / 1ps
module spq_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  spq_pkg::spq_cmd_type              cmd,
   output spq_pkg::spq_stat_type             stat,
   input  logic signed [spq_pkg::VALUE_W-1:0] req_item_value,
   input  logic signed [spq_pkg::PRIO_W-1:0]  req_item_priority,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [spq_pkg::STATUS_W-1:0]      rsp_status,
   output logic signed [spq_pkg::VALUE_W-1:0] rsp_removed_value,
   output logic [spq_pkg::FILL_W-1:0]        rsp_fill_count
);
   import spq_pkg::*;

   // queue pointers
   logic [ADDR_W-1:0] head_ff;
   logic [CNT_W-1:0]  count_ff;

   // scan pointers
   logic [ADDR_W-1:0] rd_addr_ff;
   logic [ADDR_W-1:0] cmp_addr_ff;
   logic [CNT_W-1:0]  remaining_ff;

   // held transaction and staged result
   logic signed [VALUE_W-1:0] item_value_ff;
   logic signed [PRIO_W-1:0]  item_prio_ff;
   logic [STATUS_W-1:0]       stage_status_ff;
   logic signed [VALUE_W-1:0] stage_value_ff;

   // output registers
   logic                      rsp_valid_ff;
   logic [STATUS_W-1:0]       rsp_status_ff;
   logic signed [VALUE_W-1:0] rsp_value_ff;
   logic [FILL_W-1:0]         rsp_fill_ff;

   // memory ports
   logic                      ram_wr_en;
   logic [ADDR_W-1:0]         ram_wr_addr;
   logic [ENTRY_W-1:0]        ram_wr_data;
   logic                      ram_rd_en;
   logic [ADDR_W-1:0]         ram_rd_addr;
   logic [ENTRY_W-1:0]        ram_rd_data;
   logic signed [PRIO_W-1:0]  rd_prio;
   logic [ADDR_W:0]           tail_sum;
   logic [ADDR_W-1:0]         tail_addr;

   spq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // physical address of the last held entry
   always_comb begin
      tail_sum = {1'b0, head_ff} + (ADDR_W + 1)'(count_ff) - (ADDR_W + 1)'(1);
      if (tail_sum >= (ADDR_W + 1)'(DEPTH)) begin
         tail_addr = ADDR_W'(tail_sum - (ADDR_W + 1)'(DEPTH));
      end else begin
         tail_addr = tail_sum[ADDR_W-1:0];
      end
   end

   // memory read and write selection
   assign rd_prio     = ram_rd_data[PRIO_W-1:0];
   assign ram_rd_en   = cmd.read_head || cmd.read_next;
   assign ram_rd_addr = cmd.read_head ? head_ff : rd_addr_ff;

   always_comb begin
      ram_wr_en   = cmd.shift_up || cmd.place_above || cmd.place_head;
      ram_wr_addr = addr_inc(cmp_addr_ff);
      ram_wr_data = {item_value_ff, item_prio_ff};
      if (cmd.shift_up) begin
         ram_wr_data = ram_rd_data;
      end
      if (cmd.place_head) begin
         ram_wr_addr = head_ff;
      end
   end

   // status back to the controller
   assign stat.empty     = (count_ff == '0);
   assign stat.full      = (count_ff == CNT_W'(DEPTH));
   assign stat.prio_ge   = (rd_prio >= item_prio_ff);
   assign stat.scan_last = (remaining_ff == '0);
   assign stat.rsp_busy  = rsp_valid_ff && !rsp_ready;

   // head and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (cmd.pop) begin
            head_ff  <= addr_inc(head_ff);
            count_ff <= count_ff - CNT_W'(1);
         end else if (cmd.count_inc) begin
            count_ff <= count_ff + CNT_W'(1);
         end
      end
   end

   // scan pointers, held transaction and staged result
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_value_ff   <= req_item_value;
         item_prio_ff    <= req_item_priority;
         rd_addr_ff      <= tail_addr;
         remaining_ff    <= count_ff;
         stage_status_ff <= cmd.set_status ? cmd.status_code : STATUS_OK;
         stage_value_ff  <= '0;
      end
      if (cmd.read_next) begin
         cmp_addr_ff  <= rd_addr_ff;
         rd_addr_ff   <= addr_dec(rd_addr_ff);
         remaining_ff <= remaining_ff - CNT_W'(1);
      end
      if (cmd.pop) begin
         stage_value_ff <= ram_rd_data[ENTRY_W-1:PRIO_W];
      end
   end

   // response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.respond) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_status_ff <= stage_status_ff;
         rsp_value_ff  <= stage_value_ff;
         rsp_fill_ff   <= FILL_W'(count_ff);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_value = rsp_value_ff;
   assign rsp_fill_count    = rsp_fill_ff;
endmodule

[rtl/sorted_priority_queue_top.sv]
// top level of the sorted priority queue
// Holds up to DEPTH entries (value, signed priority) ordered from highest
// priority to lowest; equal priorities leave in insert order.
// Channels: req_chan carries one transaction per command (insert or remove
// with value and priority); rsp_chan returns exactly one transaction per
// request with status, removed value and fill count after the operation.
// Entries live in a circular buffer in one memory; a remove advances the
// head pointer, an insert walks from the tail toward the head, moving each
// lower-priority entry up one slot per cycle (read and write port overlap).
// Steps per request: a remove reads the head entry, then pops it; a refused
// insert or a remove on an empty queue goes straight to the response step;
// an insert into an empty queue is placed at the head; other inserts read
// the tail, then scan toward the head past each entry of lower priority and
// place the new entry above the first of equal or higher priority, or at the
// head. A new request is taken only after the last response is loaded.
// Reset (synchronous, active high) empties the queue; the memory needs no
// clearing pass. While the receiver stalls, the response register holds its
// transaction and the next request may still be accepted and processed; it
// waits in the final step until the response register is free.
`timescale 1ns / 1ps
module sorted_priority_queue_top (
   input  logic       clock,
   input  logic       reset,
   spq_req_if.sink    req_chan,
   spq_rsp_if.source  rsp_chan
);
   import spq_pkg::*;

   spq_cmd_type  cmd;
   spq_stat_type stat;

   spq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_command (req_chan.command),
      .req_ready   (req_chan.ready),
      .stat        (stat),
      .cmd         (cmd)
   );

   spq_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_item_value    (req_chan.item_value),
      .req_item_priority (req_chan.item_priority),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_status        (rsp_chan.status),
      .rsp_removed_value (rsp_chan.removed_value),
      .rsp_fill_count    (rsp_chan.fill_count)
   );
endmodule

[sim/tb_sorted_priority_queue_top.sv]
// self-checking bench for the sorted priority queue: shadow queue, ordered response check
`timescale 1ns / 1ps
module tb_sorted_priority_queue_top;
   import spq_pkg::*;

   localparam int  CYCLE_LIMIT = 1000000;
   localparam int  DRAIN_WAIT  = 80;
   localparam int  HOLD_CYCLES = 400;
   localparam int  MAX_SHOWN   = 10;

   // one response as the queue should produce it
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  removed_value;
      logic [FILL_W-1:0]   fill_count;
   } queue_outcome_type;

   logic clock = 1'b0;
   logic reset;

   spq_req_if req_chan ();
   spq_rsp_if rsp_chan ();

   sorted_priority_queue_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // shadow copy of the queue contents, highest priority at slot 0
   logic signed [VALUE_W-1:0] held_value [DEPTH];
   logic signed [PRIO_W-1:0]  held_prio  [DEPTH];
   int                        held_count = 0;

   queue_outcome_type pending_outcomes [$];
   int                error_count   = 0;
   int                cycle_count   = 0;
   int                hold_request  = 0;
   bit                idle_en       = 1'b1;

   always #10 clock = ~clock;

   // cycle budget
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_sorted_priority_queue_top: FAIL");
         $finish;
      end
   end

   // apply one accepted transaction to the shadow queue, return its response
   function automatic queue_outcome_type apply_queue_op(input logic cmd,
                                                        input logic [VALUE_W-1:0] val,
                                                        input logic signed [PRIO_W-1:0] pr);
      queue_outcome_type res;
      int slot;
      res.status        = STATUS_OK;
      res.removed_value = '0;
      if (cmd == CMD_INSERT) begin
         if (held_count >= DEPTH) begin
            res.status = STATUS_OVERFLOW;
         end else begin
            // new entry goes behind every entry of equal or higher priority
            slot = 0;
            while (slot < held_count && held_prio[slot] >= pr) slot++;
            for (int i = held_count; i > slot; i--) begin
               held_value[i] = held_value[i-1];
               held_prio[i]  = held_prio[i-1];
            end
            held_value[slot] = val;
            held_prio[slot]  = pr;
            held_count++;
         end
      end else begin
         if (held_count == 0) begin
            res.status = STATUS_UNDERFLOW;
         end else begin
            res.removed_value = held_value[0];
            for (int i = 1; i < held_count; i++) begin
               held_value[i-1] = held_value[i];
               held_prio[i-1]  = held_prio[i];
            end
            held_count--;
         end
      end
      res.fill_count = FILL_W'(held_count);
      return res;
   endfunction

   // mix of tie-heavy, extreme and fully random priorities
   function automatic logic signed [PRIO_W-1:0] random_priority();
      logic signed [PRIO_W-1:0] p;
      case ($urandom_range(0, 3))
         0: p = PRIO_W'($signed($urandom_range(0, 6)) - 3);
         1: p = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         default: p = PRIO_W'($urandom());
      endcase
      return p;
   endfunction

   // offer one transaction and wait until it is taken
   task automatic send_op(input logic cmd, input logic [VALUE_W-1:0] val,
                          input logic signed [PRIO_W-1:0] pr);
      int gap;
      if (idle_en && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 16);
         req_chan.valid         <= 1'b0;
         req_chan.command       <= 1'($urandom());
         req_chan.item_value    <= $urandom();
         req_chan.item_priority <= PRIO_W'($urandom());
         repeat (gap) @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.command       <= cmd;
      req_chan.item_value    <= val;
      req_chan.item_priority <= pr;
      do @(posedge clock); while (!req_chan.ready);
      pending_outcomes.push_back(apply_queue_op(cmd, val, pr));
   endtask

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      int n;
      forever begin
         if (hold_request > 0) begin
            n = hold_request;
            hold_request = 0;
            rsp_chan.ready <= 1'b0;
         end else if (idle_en && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 16);
            rsp_chan.ready <= 1'b0;
         end else begin
            n = 1;
            rsp_chan.ready <= 1'b1;
         end
         repeat (n) @(posedge clock);
      end
   end

   // compare each response transaction against the oldest expected one
   always @(posedge clock) begin : check_response
      queue_outcome_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_outcomes.size() == 0) begin
            error_count++;
            if (error_count <= MAX_SHOWN)
               $display("%0t: response with none pending: status %0d value %h fill %0d",
                        $realtime, rsp_chan.status, rsp_chan.removed_value,
                        rsp_chan.fill_count);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_chan.status !== want.status
                || rsp_chan.removed_value !== want.removed_value
                || rsp_chan.fill_count !== want.fill_count) begin
               error_count++;
               if (error_count <= MAX_SHOWN)
                  $display("%0t: mismatch exp status %0d value %h fill %0d, got %0d %h %0d",
                           $realtime, want.status, want.removed_value, want.fill_count,
                           rsp_chan.status, rsp_chan.removed_value, rsp_chan.fill_count);
            end
         end
      end
   end

   // remove on an empty queue
   task automatic test_underflow();
      send_op(CMD_REMOVE, 32'h5A5A_A5A5, 16'sh1234);
   endtask

   // field extremes, equal priorities, then drain past empty
   task automatic test_ordering_extremes();
      send_op(CMD_INSERT, 32'h7FFF_FFFF, 16'sh8000);
      send_op(CMD_INSERT, 32'h8000_0000, 16'sh7FFF);
      send_op(CMD_INSERT, 32'h0000_0000, 16'sh0000);
      send_op(CMD_INSERT, 32'hFFFF_FFFF, 16'shFFFF);
      send_op(CMD_INSERT, 32'h0000_0011, 16'sd100);
      send_op(CMD_INSERT, 32'h0000_0022, 16'sd100);
      send_op(CMD_INSERT, 32'h0000_0033, 16'sd100);
      send_op(CMD_INSERT, 32'h0000_0005, 16'sh7FFF);
      repeat (9) send_op(CMD_REMOVE, $urandom(), random_priority());
   endtask

   // fill to capacity, try a few refused inserts, drain past empty
   task automatic test_fill_and_overflow();
      while (held_count < DEPTH) send_op(CMD_INSERT, $urandom(), random_priority());
      repeat (3) send_op(CMD_INSERT, $urandom(), random_priority());
      while (held_count > 0) send_op(CMD_REMOVE, $urandom(), random_priority());
      send_op(CMD_REMOVE, $urandom(), random_priority());
   endtask

   // receiver holds off while the sender keeps offering
   task automatic test_receiver_holdoff();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      hold_request = HOLD_CYCLES;
      @(posedge clock);
      repeat (40) begin
         if ($urandom_range(0, 9) < 6) send_op(CMD_INSERT, $urandom(), random_priority());
         else send_op(CMD_REMOVE, $urandom(), random_priority());
      end
   endtask

   // phases biased toward filling, balancing or draining
   task automatic test_random_mix(input int n_items);
      int done;
      int phase_len;
      int insert_pct;
      done = 0;
      while (done < n_items) begin
         phase_len = $urandom_range(20, 80);
         case ($urandom_range(0, 2))
            0: insert_pct = 85;
            1: insert_pct = 50;
            default: insert_pct = 15;
         endcase
         repeat (phase_len) begin
            if ($urandom_range(1, 100) <= insert_pct)
               send_op(CMD_INSERT, $urandom(), random_priority());
            else
               send_op(CMD_REMOVE, $urandom(), random_priority());
            done++;
         end
      end
   endtask

   // back to back traffic with no idling on either side
   task automatic test_full_rate();
      idle_en = 1'b0;
      test_random_mix(300);
   endtask

   initial begin
      reset                  <= 1'b1;
      req_chan.valid         <= 1'b0;
      req_chan.command       <= CMD_INSERT;
      req_chan.item_value    <= '0;
      req_chan.item_priority <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_underflow();
      test_ordering_extremes();
      test_fill_and_overflow();
      test_receiver_holdoff();
      test_random_mix(1000);
      test_full_rate();

      // let every outstanding response come back
      req_chan.valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (error_count == 0) begin
         $display("tb_sorted_priority_queue_top: PASS");
      end else begin
         $display("tb_sorted_priority_queue_top: FAIL");
      end
      $finish;
   end

endmodule
